// ----- hdl/cllm_pkg.sv -----
// shared types and codes for the cursor linked list manager
package cllm_pkg;

  typedef enum logic [3:0] {
    REQ_INS_HEAD   = 4'd0,
    REQ_INS_TAIL   = 4'd1,
    REQ_INS_POS    = 4'd2,
    REQ_INS_SORTED = 4'd3,
    REQ_DEL_HEAD   = 4'd4,
    REQ_DEL_TAIL   = 4'd5,
    REQ_DEL_POS    = 4'd6,
    REQ_DEL_TAG    = 4'd7,
    REQ_WALK       = 4'd8
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_SLOT,
    SEL_CUR
  } slot_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INS_FREE,
    S_SCAN,
    S_LINK,
    S_LINK2,
    S_DSCAN,
    S_UNLINK,
    S_FREE,
    S_WALK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [15:0] entry_key;
    logic [15:0] entry_tag;
    logic [7:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [4:0]  entries;
    logic [15:0] out_key;
    logic [15:0] out_tag;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      ins_start;
    logic      ins_free;
    logic      scan_rd;
    logic      advance;
    logic      link_slot;
    logic      link_prev;
    logic      del_start;
    logic      save_nxt;
    logic      unlink;
    logic      free_cur;
    logic      walk_emit;
    logic      resp_emit;
    status_t   resp_status;
    slot_sel_t resp_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       free_null;
    logic       head_null;
    logic       cur_null;
    logic       prev_null;
    logic       nxt_null;
    logic       key_lt;
    logic       tag_eq;
    logic       steps_ge_pos;
    logic       pos_ge_count;
    logic       walk_last;
    logic       out_free;
  } dp_stat_t;

endpackage

// ----- hdl/cllm_dp.sv -----
// datapath: slot memories, list pointers, scan registers and result register
module cllm_dp #(
  parameter int POOL_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_ld,
  input  cllm_pkg::in_item_t  in_data,
  input  cllm_pkg::dp_cmd_t   cmd,
  output cllm_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output cllm_pkg::out_item_t out_data,
  input  logic                out_stall
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int IW = $clog2(POOL_DEPTH + 1);
  localparam logic [IW-1:0] NUL = IW'(POOL_DEPTH);

  cllm_pkg::in_item_t  req_r;
  cllm_pkg::out_item_t out_r;
  logic                out_valid_r;

  logic [IW-1:0] head_r, free_r, count_r, cur_r, prev_r, slot_r, nxt_r, steps_r;
  logic [3:0]    n_r;
  logic [IW-1:0] link_q_r;
  logic [15:0]   key_q_r, tag_q_r;

  logic [IW-1:0]         link_mem [POOL_DEPTH];
  logic [15:0]           key_mem  [POOL_DEPTH];
  logic [15:0]           tag_mem  [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] lvalid_r;

  logic          rd_req, rd_en;
  logic [IW-1:0] rd_idx;
  logic          lwe;
  logic [IW-1:0] lwa, lwd;
  logic          out_free, out_ld;
  logic [AW-1:0] ra, wa, ka;

  always_comb begin
    rd_req = 1'b0;
    rd_idx = cur_r;
    if (cmd.ins_start) begin
      rd_req = 1'b1;
      rd_idx = free_r;
    end else if (cmd.scan_rd) begin
      rd_req = 1'b1;
      rd_idx = cur_r;
    end else if (cmd.advance || cmd.walk_emit) begin
      rd_req = 1'b1;
      rd_idx = link_q_r;
    end else if (cmd.del_start) begin
      rd_req = 1'b1;
      rd_idx = head_r;
    end
    rd_en = rd_req && (rd_idx != NUL);

    lwe = 1'b0;
    lwa = slot_r;
    lwd = cur_r;
    if (cmd.link_slot) begin
      lwe = 1'b1;
    end else if (cmd.link_prev) begin
      lwe = 1'b1;
      lwa = prev_r;
      lwd = slot_r;
    end else if (cmd.unlink && (prev_r != NUL)) begin
      lwe = 1'b1;
      lwa = prev_r;
      lwd = nxt_r;
    end else if (cmd.free_cur) begin
      lwe = 1'b1;
      lwa = cur_r;
      lwd = free_r;
    end
  end

  assign ra = rd_idx[AW-1:0];
  assign wa = lwa[AW-1:0];
  assign ka = free_r[AW-1:0];

  // slot memories, one read port shared by all three stores
  always_ff @(posedge clk) begin
    if (lwe) begin
      link_mem[wa] <= lwd;
    end
    if (cmd.ins_start) begin
      key_mem[ka] <= req_r.entry_key;
      tag_mem[ka] <= req_r.entry_tag;
    end
    if (rd_en) begin
      link_q_r <= lvalid_r[ra] ? link_mem[ra] : (IW'(ra) + IW'(1));
      key_q_r  <= key_mem[ra];
      tag_q_r  <= tag_mem[ra];
    end
  end

  // unwritten link entries read as their reset chain value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r <= '0;
    end else if (lwe) begin
      lvalid_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NUL;
      free_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.ins_free) begin
        free_r <= link_q_r;
      end
      if (cmd.link_slot) begin
        count_r <= count_r + IW'(1);
        if (prev_r == NUL) begin
          head_r <= slot_r;
        end
      end
      if (cmd.unlink && (prev_r == NUL)) begin
        head_r <= nxt_r;
      end
      if (cmd.free_cur) begin
        free_r  <= cur_r;
        count_r <= count_r - IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ld) begin
      req_r <= in_data;
    end
    if (cmd.ins_start) begin
      slot_r  <= free_r;
      cur_r   <= head_r;
      prev_r  <= NUL;
      steps_r <= '0;
    end
    if (cmd.del_start) begin
      cur_r   <= head_r;
      prev_r  <= NUL;
      steps_r <= '0;
      n_r     <= '0;
    end
    if (cmd.advance) begin
      prev_r  <= cur_r;
      cur_r   <= link_q_r;
      steps_r <= steps_r + IW'(1);
    end
    if (cmd.walk_emit) begin
      cur_r <= link_q_r;
      n_r   <= n_r + 4'd1;
    end
    if (cmd.save_nxt) begin
      nxt_r <= link_q_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_ld   = cmd.walk_emit || cmd.resp_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_emit) begin
      out_r.status  <= cllm_pkg::ST_OK;
      out_r.slot    <= 4'(cur_r);
      out_r.entries <= 5'(count_r);
      out_r.out_key <= key_q_r;
      out_r.out_tag <= tag_q_r;
      out_r.last    <= stat.walk_last;
    end else if (cmd.resp_emit) begin
      out_r.status  <= cmd.resp_status;
      case (cmd.resp_sel)
        cllm_pkg::SEL_SLOT: out_r.slot <= 4'(slot_r);
        cllm_pkg::SEL_CUR:  out_r.slot <= 4'(cur_r);
        default:            out_r.slot <= 4'd0;
      endcase
      out_r.entries <= 5'(count_r);
      out_r.out_key <= 16'd0;
      out_r.out_tag <= 16'd0;
      out_r.last    <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.kind         = req_r.req_type;
  assign stat.free_null    = (free_r == NUL);
  assign stat.head_null    = (head_r == NUL);
  assign stat.cur_null     = (cur_r == NUL);
  assign stat.prev_null    = (prev_r == NUL);
  assign stat.nxt_null     = (link_q_r == NUL);
  assign stat.key_lt       = (key_q_r < req_r.entry_key);
  assign stat.tag_eq       = (tag_q_r == req_r.entry_tag);
  assign stat.steps_ge_pos = (9'(steps_r) >= 9'(req_r.position));
  assign stat.pos_ge_count = (9'(req_r.position) >= 9'(count_r));
  assign stat.walk_last    = (link_q_r == NUL) || (n_r == 4'd15);
  assign stat.out_free     = out_free;

endmodule

// ----- hdl/cllm_ctrl.sv -----
// controller state machine sequencing list operations
module cllm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               in_ld,
  input  cllm_pkg::dp_stat_t stat,
  output cllm_pkg::dp_cmd_t  cmd
);

  cllm_pkg::state_t    state_r, state_nxt;
  cllm_pkg::status_t   rstat_r, rstat_nxt;
  cllm_pkg::slot_sel_t rsel_r, rsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cllm_pkg::S_IDLE;
      rstat_r <= cllm_pkg::ST_OK;
      rsel_r  <= cllm_pkg::SEL_ZERO;
    end else begin
      state_r <= state_nxt;
      rstat_r <= rstat_nxt;
      rsel_r  <= rsel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rstat_nxt = rstat_r;
    rsel_nxt  = rsel_r;
    cmd       = '0;
    cmd.resp_status = rstat_r;
    cmd.resp_sel    = rsel_r;
    in_stall  = (state_r != cllm_pkg::S_IDLE);
    in_ld     = 1'b0;

    unique case (state_r)
      cllm_pkg::S_IDLE: begin
        if (in_valid) begin
          in_ld     = 1'b1;
          state_nxt = cllm_pkg::S_DISP;
        end
      end
      cllm_pkg::S_DISP: begin
        state_nxt = cllm_pkg::S_RESP;
        rsel_nxt  = cllm_pkg::SEL_ZERO;
        case (stat.kind) inside
          [cllm_pkg::REQ_INS_HEAD:cllm_pkg::REQ_INS_SORTED]: begin
            if (stat.free_null) begin
              rstat_nxt = cllm_pkg::ST_FULL;
            end else begin
              cmd.ins_start = 1'b1;
              state_nxt     = cllm_pkg::S_INS_FREE;
            end
          end
          [cllm_pkg::REQ_DEL_HEAD:cllm_pkg::REQ_DEL_TAG]: begin
            if (stat.head_null) begin
              rstat_nxt = cllm_pkg::ST_EMPTY;
            end else if (stat.kind == cllm_pkg::REQ_DEL_POS && stat.pos_ge_count) begin
              rstat_nxt = cllm_pkg::ST_NOT_FOUND;
            end else begin
              cmd.del_start = 1'b1;
              state_nxt     = cllm_pkg::S_DSCAN;
            end
          end
          cllm_pkg::REQ_WALK: begin
            if (stat.head_null) begin
              rstat_nxt = cllm_pkg::ST_EMPTY;
            end else begin
              cmd.del_start = 1'b1;
              state_nxt     = cllm_pkg::S_WALK;
            end
          end
          default: begin
            rstat_nxt = cllm_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      cllm_pkg::S_INS_FREE: begin
        cmd.ins_free = 1'b1;
        if (stat.kind == cllm_pkg::REQ_INS_HEAD || stat.cur_null) begin
          state_nxt = cllm_pkg::S_LINK;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = cllm_pkg::S_SCAN;
        end
      end
      cllm_pkg::S_SCAN: begin
        if ((stat.kind == cllm_pkg::REQ_INS_POS && stat.steps_ge_pos) ||
            (stat.kind == cllm_pkg::REQ_INS_SORTED && !stat.key_lt)) begin
          state_nxt = cllm_pkg::S_LINK;
        end else begin
          cmd.advance = 1'b1;
          if (stat.nxt_null) begin
            state_nxt = cllm_pkg::S_LINK;
          end
        end
      end
      cllm_pkg::S_LINK: begin
        cmd.link_slot = 1'b1;
        rstat_nxt     = cllm_pkg::ST_OK;
        rsel_nxt      = cllm_pkg::SEL_SLOT;
        state_nxt     = stat.prev_null ? cllm_pkg::S_RESP : cllm_pkg::S_LINK2;
      end
      cllm_pkg::S_LINK2: begin
        cmd.link_prev = 1'b1;
        state_nxt     = cllm_pkg::S_RESP;
      end
      cllm_pkg::S_DSCAN: begin
        case (stat.kind)
          cllm_pkg::REQ_DEL_HEAD: begin
            cmd.save_nxt = 1'b1;
            state_nxt    = cllm_pkg::S_UNLINK;
          end
          cllm_pkg::REQ_DEL_TAIL: begin
            if (stat.nxt_null) begin
              cmd.save_nxt = 1'b1;
              state_nxt    = cllm_pkg::S_UNLINK;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          cllm_pkg::REQ_DEL_POS: begin
            if (stat.steps_ge_pos) begin
              cmd.save_nxt = 1'b1;
              state_nxt    = cllm_pkg::S_UNLINK;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          default: begin
            if (stat.tag_eq) begin
              cmd.save_nxt = 1'b1;
              state_nxt    = cllm_pkg::S_UNLINK;
            end else if (stat.nxt_null) begin
              rstat_nxt = cllm_pkg::ST_NOT_FOUND;
              rsel_nxt  = cllm_pkg::SEL_ZERO;
              state_nxt = cllm_pkg::S_RESP;
            end else begin
              cmd.advance = 1'b1;
            end
          end
        endcase
      end
      cllm_pkg::S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = cllm_pkg::S_FREE;
      end
      cllm_pkg::S_FREE: begin
        cmd.free_cur = 1'b1;
        rstat_nxt    = cllm_pkg::ST_OK;
        rsel_nxt     = cllm_pkg::SEL_CUR;
        state_nxt    = cllm_pkg::S_RESP;
      end
      cllm_pkg::S_WALK: begin
        if (stat.out_free) begin
          cmd.walk_emit = 1'b1;
          if (stat.walk_last) begin
            state_nxt = cllm_pkg::S_IDLE;
          end
        end
      end
      cllm_pkg::S_RESP: begin
        if (stat.out_free) begin
          cmd.resp_emit = 1'b1;
          state_nxt     = cllm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cllm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/cursor_linked_list_manager.sv -----
// top level of the cursor linked list manager: controller plus datapath
// Keeps a singly linked list and a free stack over POOL_DEPTH slots, each
// holding a key, a tag and a link. One item is handled at a time; the input
// stalls from acceptance until the last result of that item is loaded into
// the output register. A walk emits at most sixteen entries. A rejected
// request (pool full, list empty, bad position, unknown kind) gets a single
// response. While the output is stalled, a waiting result holds the item.
// List scans are paced by the single read port of the slot memories, which
// follows one link per cycle. Link entries never written read back as the
// reset chain, so no clearing pass runs after reset.
module cursor_linked_list_manager #(
  parameter int POOL_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cllm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cllm_pkg::out_item_t out_data
);

  // command and status between the sequencer and the datapath
  cllm_pkg::dp_cmd_t  cmd;
  cllm_pkg::dp_stat_t stat;
  logic               in_ld;

  // sequencer: dispatch on request kind, one link hop per scan state
  cllm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ld    (in_ld),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot memories, pointers and the output register
  cllm_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ld     (in_ld),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
